// ===== design/rth_pkg.sv =====
// Shared types and constants for the ray/triangle hit test pipeline.
// No dependencies; used by ray_triangle_hit_test, by its checkers and by the testbench.
package rth_pkg;

    // Coordinate and register widths
    localparam int COORD_W   = 16;
    localparam int TOL_W     = 52;
    localparam int CFG_DATA_W = TOL_W;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd6;

    // Miss reason codes, in check order
    localparam logic [2:0] RSN_HIT      = 3'd0;
    localparam logic [2:0] RSN_CULLED   = 3'd1;
    localparam logic [2:0] RSN_PARALLEL = 3'd2;
    localparam logic [2:0] RSN_B1_NEG   = 3'd3;
    localparam logic [2:0] RSN_B2_NEG   = 3'd4;
    localparam logic [2:0] RSN_SUM_OVER = 3'd5;
    localparam logic [2:0] RSN_BEHIND   = 3'd6;

    // Pipeline depth from accept to result strobe
    localparam int LATENCY = 6;

    // One triangle item
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by_coord;
        logic [COORD_W-1:0] bz;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic               face_culled;
    } t_item;

    // One result item
    typedef struct packed {
        logic       hit;
        logic [2:0] miss_reason;
    } t_result;

endpackage

// ===== design/rth_cross.sv =====
// Two-stage registered 3D cross product: products, then differences.
// Depends on nothing; instantiated by ray_triangle_hit_test.
module rth_cross #(
    parameter int AW = 17,
    parameter int BW = 17
) (
    input  logic                   i_clk,
    input  logic signed [AW-1:0]   i_a [3],
    input  logic signed [BW-1:0]   i_b [3],
    output logic signed [AW+BW:0]  o_r [3]
);

    localparam int PW = AW + BW;

    logic signed [PW-1:0] r_p [6];
    logic signed [PW:0]   r_c [3];

    // stage 1: six partial products
    always_ff @(posedge i_clk) begin
        r_p[0] <= i_a[1] * i_b[2];
        r_p[1] <= i_a[2] * i_b[1];
        r_p[2] <= i_a[2] * i_b[0];
        r_p[3] <= i_a[0] * i_b[2];
        r_p[4] <= i_a[0] * i_b[1];
        r_p[5] <= i_a[1] * i_b[0];
    end

    // stage 2: component differences, one bit of growth
    always_ff @(posedge i_clk) begin
        r_c[0] <= (PW+1)'(r_p[0]) - (PW+1)'(r_p[1]);
        r_c[1] <= (PW+1)'(r_p[2]) - (PW+1)'(r_p[3]);
        r_c[2] <= (PW+1)'(r_p[4]) - (PW+1)'(r_p[5]);
    end

    assign o_r = r_c;

endmodule

// ===== design/rth_dot.sv =====
// Two-stage registered 3D dot product: products, then a three-way sum.
// Depends on nothing; instantiated by ray_triangle_hit_test.
module rth_dot #(
    parameter int AW = 16,
    parameter int BW = 35
) (
    input  logic                     i_clk,
    input  logic signed [AW-1:0]     i_a [3],
    input  logic signed [BW-1:0]     i_b [3],
    output logic signed [AW+BW+1:0]  o_s
);

    localparam int PW = AW + BW;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] r_p [3];
    logic signed [SW-1:0] r_s;

    // stage 1: per-axis products
    always_ff @(posedge i_clk) begin
        r_p[0] <= i_a[0] * i_b[0];
        r_p[1] <= i_a[1] * i_b[1];
        r_p[2] <= i_a[2] * i_b[2];
    end

    // stage 2: sum, two bits of growth
    always_ff @(posedge i_clk) begin
        r_s <= SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]);
    end

    assign o_s = r_s;

endmodule

// ===== design/ray_triangle_hit_test.sv =====
// Ray/triangle hit test: ray in config registers, one triangle item per cycle.
// Throughput one item per cycle, busy stays low. Six register stages: edges,
// cross products (2), dot products (2), classification. Synchronous active-low
// reset clears the valid pipeline and all config registers; the receiver
// cannot stall. Depends on rth_pkg, rth_cross and rth_dot.
module ray_triangle_hit_test (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  rth_pkg::t_item                    i_item,
    output logic                              o_busy,
    output logic                              o_valid,
    output rth_pkg::t_result                  o_result,
    input  logic                              i_cfg_we,
    input  logic [rth_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rth_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW  = rth_pkg::COORD_W;
    localparam int EW  = CW + 1;            // edge / Q vectors
    localparam int NW  = 2 * EW + 1;        // cross products
    localparam int DW  = CW + NW + 2;       // D dot cross
    localparam int QNW = EW + NW + 2;       // Q dot N
    localparam int KW  = QNW + 2;           // compare width
    localparam int LAT = rth_pkg::LATENCY;

    // Configuration registers
    logic [rth_pkg::TOL_W-1:0] r_tol;
    logic signed [CW-1:0]      r_org [3];
    logic signed [CW-1:0]      r_dir [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rth_pkg::CFG_TOL:   r_tol    <= i_cfg_data[rth_pkg::TOL_W-1:0];
                rth_pkg::CFG_ORG_X: r_org[0] <= $signed(i_cfg_data[CW-1:0]);
                rth_pkg::CFG_ORG_Y: r_org[1] <= $signed(i_cfg_data[CW-1:0]);
                rth_pkg::CFG_ORG_Z: r_org[2] <= $signed(i_cfg_data[CW-1:0]);
                rth_pkg::CFG_DIR_X: r_dir[0] <= $signed(i_cfg_data[CW-1:0]);
                rth_pkg::CFG_DIR_Y: r_dir[1] <= $signed(i_cfg_data[CW-1:0]);
                rth_pkg::CFG_DIR_Z: r_dir[2] <= $signed(i_cfg_data[CW-1:0]);
                default: ;
            endcase
        end
    end

    // Fully pipelined, never busy
    assign o_busy = 1'b0;

    // Valid and culled flags travel with the item
    logic [LAT:1] r_vld;
    logic [LAT-1:1] r_cul;
    logic n_take;

    assign n_take = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], n_take};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cul <= {r_cul[LAT-2:1], i_item.face_culled};
    end

    // Stage 1: edges and origin offset
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [EW-1:0] r_q1 [3];
    logic signed [EW-1:0] r_q2 [3];
    logic signed [EW-1:0] r_q3 [3];
    logic signed [CW-1:0] n_a [3];
    logic signed [CW-1:0] n_b [3];
    logic signed [CW-1:0] n_c [3];

    always_comb begin
        n_a[0] = $signed(i_item.ax);
        n_a[1] = $signed(i_item.ay);
        n_a[2] = $signed(i_item.az);
        n_b[0] = $signed(i_item.bx);
        n_b[1] = $signed(i_item.by_coord);
        n_b[2] = $signed(i_item.bz);
        n_c[0] = $signed(i_item.cx);
        n_c[1] = $signed(i_item.cy);
        n_c[2] = $signed(i_item.cz);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= EW'(n_b[i]) - EW'(n_a[i]);
            r_e2[i] <= EW'(n_c[i]) - EW'(n_a[i]);
            r_q1[i] <= EW'(r_org[i]) - EW'(n_a[i]);
            // Q delayed to line up with the cross products
            r_q2[i] <= r_q1[i];
            r_q3[i] <= r_q2[i];
        end
    end

    // Stages 2-3: normal and the two barycentric cross products
    logic signed [NW-1:0] w_n  [3];
    logic signed [NW-1:0] w_t1 [3];
    logic signed [NW-1:0] w_t2 [3];

    rth_cross #(.AW(EW), .BW(EW)) u_cross_n (
        .i_clk (i_clk),
        .i_a   (r_e1),
        .i_b   (r_e2),
        .o_r   (w_n)
    );

    rth_cross #(.AW(EW), .BW(EW)) u_cross_t1 (
        .i_clk (i_clk),
        .i_a   (r_q1),
        .i_b   (r_e2),
        .o_r   (w_t1)
    );

    rth_cross #(.AW(EW), .BW(EW)) u_cross_t2 (
        .i_clk (i_clk),
        .i_a   (r_e1),
        .i_b   (r_q1),
        .o_r   (w_t2)
    );

    // Stages 4-5: dot products
    logic signed [DW-1:0]  w_ddn;
    logic signed [DW-1:0]  w_b1;
    logic signed [DW-1:0]  w_b2;
    logic signed [QNW-1:0] w_qdn;

    rth_dot #(.AW(CW), .BW(NW)) u_dot_dn (
        .i_clk (i_clk),
        .i_a   (r_dir),
        .i_b   (w_n),
        .o_s   (w_ddn)
    );

    rth_dot #(.AW(CW), .BW(NW)) u_dot_b1 (
        .i_clk (i_clk),
        .i_a   (r_dir),
        .i_b   (w_t1),
        .o_s   (w_b1)
    );

    rth_dot #(.AW(CW), .BW(NW)) u_dot_b2 (
        .i_clk (i_clk),
        .i_a   (r_dir),
        .i_b   (w_t2),
        .o_s   (w_b2)
    );

    rth_dot #(.AW(EW), .BW(NW)) u_dot_qn (
        .i_clk (i_clk),
        .i_a   (r_q3),
        .i_b   (w_n),
        .o_s   (w_qdn)
    );

    // Stage 6: sign fold and ordered checks
    logic signed [KW-1:0] n_tol;
    logic signed [KW-1:0] n_ddn;
    logic signed [KW-1:0] n_b1;
    logic signed [KW-1:0] n_b2;
    logic signed [KW-1:0] n_qdn;
    logic                 n_pos;
    logic                 n_neg;
    logic [2:0]           n_rsn;

    always_comb begin
        n_tol = $signed(KW'(r_tol));
        n_pos = n_tol < KW'(w_ddn);
        n_neg = KW'(w_ddn) < -n_tol;
        n_ddn = n_neg ? -KW'(w_ddn) : KW'(w_ddn);
        n_b1  = n_neg ? -KW'(w_b1)  : KW'(w_b1);
        n_b2  = n_neg ? -KW'(w_b2)  : KW'(w_b2);
        n_qdn = n_pos ? -KW'(w_qdn) : KW'(w_qdn);

        if (r_cul[LAT-1]) begin
            n_rsn = rth_pkg::RSN_CULLED;
        end else if (!n_pos && !n_neg) begin
            n_rsn = rth_pkg::RSN_PARALLEL;
        end else if (n_b1 < 0) begin
            n_rsn = rth_pkg::RSN_B1_NEG;
        end else if (n_b2 < 0) begin
            n_rsn = rth_pkg::RSN_B2_NEG;
        end else if (n_ddn < n_b1 + n_b2) begin
            n_rsn = rth_pkg::RSN_SUM_OVER;
        end else if (n_qdn < 0) begin
            n_rsn = rth_pkg::RSN_BEHIND;
        end else begin
            n_rsn = rth_pkg::RSN_HIT;
        end
    end

    // Output register
    rth_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        r_res.miss_reason <= n_rsn;
        r_res.hit         <= (n_rsn == rth_pkg::RSN_HIT);
    end

    assign o_valid  = r_vld[LAT];
    assign o_result = r_res;

endmodule

// ===== design/rth_check.sv =====
// Port-level checker for ray_triangle_hit_test, attached with bind below.
// Depends on rth_pkg.
module rth_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input rth_pkg::t_item                 i_item,
    input logic                           o_busy,
    input logic                           o_valid,
    input rth_pkg::t_result               o_result
);

    // every accepted item yields a strobe after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##6 o_valid)
        else $error("accepted item produced no result");

    // a strobe is always backed by an accepted item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 6))
        else $error("result without an accepted item");

    // hit flag agrees with reason code
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.hit == (o_result.miss_reason == rth_pkg::RSN_HIT)))
        else $error("hit and miss reason disagree");

    // culled items always report culled
    a_culled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_item.face_culled, 6))
            |-> (o_result.miss_reason == rth_pkg::RSN_CULLED))
        else $error("culled item not reported as culled");

endmodule

bind ray_triangle_hit_test rth_check u_rth_check (.*);

// ===== sim/rth_hit_checker.sv =====
// Checker for ray_triangle_hit_test: mirrors the ray registers, predicts the
// result of every accepted triangle item and compares it with the block's output.
// Depends on rth_pkg.
module rth_hit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  rth_pkg::t_item                 i_item,
    input  logic                           i_valid,
    input  rth_pkg::t_result               i_result,
    input  logic                           i_cfg_we,
    input  logic [rth_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rth_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    // Wide enough that no product of 16-bit coordinates can overflow
    typedef logic signed [127:0] t_wide;

    // Shadow copy of the ray registers
    logic [rth_pkg::TOL_W-1:0]   tol_reg;
    logic [rth_pkg::COORD_W-1:0] org_x, org_y, org_z;
    logic [rth_pkg::COORD_W-1:0] dir_x, dir_y, dir_z;

    rth_pkg::t_result expected_hits[$];
    rth_pkg::t_result want;
    int               mismatches = 0;

    // Scalar triple product u . (v x w)
    function automatic t_wide triple(t_wide ux, t_wide uy, t_wide uz,
                                     t_wide vx, t_wide vy, t_wide vz,
                                     t_wide wx, t_wide wy, t_wide wz);
        return ux * (vy * wz - vz * wy)
             + uy * (vz * wx - vx * wz)
             + uz * (vx * wy - vy * wx);
    endfunction

    // Expected hit flag and miss reason for one triangle against the current ray
    function automatic rth_pkg::t_result classify_triangle(rth_pkg::t_item it);
        t_wide   ax, ay, az;
        t_wide   e1x, e1y, e1z, e2x, e2y, e2z, qx, qy, qz;
        t_wide   dx, dy, dz;
        t_wide   dn, b1, b2, qn, tolw;
        logic    parallel;
        logic [2:0] reason;
        rth_pkg::t_result res;
        ax  = $signed(it.ax);
        ay  = $signed(it.ay);
        az  = $signed(it.az);
        e1x = t_wide'($signed(it.bx)) - ax;
        e1y = t_wide'($signed(it.by_coord)) - ay;
        e1z = t_wide'($signed(it.bz)) - az;
        e2x = t_wide'($signed(it.cx)) - ax;
        e2y = t_wide'($signed(it.cy)) - ay;
        e2z = t_wide'($signed(it.cz)) - az;
        qx  = t_wide'($signed(org_x)) - ax;
        qy  = t_wide'($signed(org_y)) - ay;
        qz  = t_wide'($signed(org_z)) - az;
        dx  = $signed(dir_x);
        dy  = $signed(dir_y);
        dz  = $signed(dir_z);
        tolw = {{(128-rth_pkg::TOL_W){1'b0}}, tol_reg};

        // D.N, the two barycentric numerators and the ray-side term
        dn = triple(dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z);
        b1 = triple(dx, dy, dz, qx, qy, qz, e2x, e2y, e2z);
        b2 = triple(dx, dy, dz, e1x, e1y, e1z, qx, qy, qz);
        qn = triple(qx, qy, qz, e1x, e1y, e1z, e2x, e2y, e2z);

        // fold the sign of D.N into the terms; inside the tolerance band is parallel
        parallel = 1'b0;
        if (dn > tolw) begin
            qn = -qn;
        end else if (dn < -tolw) begin
            dn = -dn;
            b1 = -b1;
            b2 = -b2;
        end else begin
            parallel = 1'b1;
        end

        if (it.face_culled)       reason = rth_pkg::RSN_CULLED;
        else if (parallel)        reason = rth_pkg::RSN_PARALLEL;
        else if (b1 < 0)          reason = rth_pkg::RSN_B1_NEG;
        else if (b2 < 0)          reason = rth_pkg::RSN_B2_NEG;
        else if (b1 + b2 > dn)    reason = rth_pkg::RSN_SUM_OVER;
        else if (qn < 0)          reason = rth_pkg::RSN_BEHIND;
        else                      reason = rth_pkg::RSN_HIT;

        res.hit         = (reason == rth_pkg::RSN_HIT);
        res.miss_reason = reason;
        return res;
    endfunction

    // Predict on accept, compare on strobe, track register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tol_reg = '0;
            org_x = '0; org_y = '0; org_z = '0;
            dir_x = '0; dir_y = '0; dir_z = '0;
            expected_hits.delete();
        end else begin
            if (i_start && !i_busy)
                expected_hits.insert(expected_hits.size(), classify_triangle(i_item));

            if (i_valid) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result hit=%0b reason=%0d",
                                 $realtime, i_result.hit, i_result.miss_reason);
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit !== i_result.hit ||
                        want.miss_reason !== i_result.miss_reason) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch hit exp %0b got %0b, reason exp %0d got %0d",
                                     $realtime, want.hit, i_result.hit,
                                     want.miss_reason, i_result.miss_reason);
                    end
                end
            end

            // unmapped indexes are ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rth_pkg::CFG_TOL:   tol_reg = i_cfg_data[rth_pkg::TOL_W-1:0];
                    rth_pkg::CFG_ORG_X: org_x   = i_cfg_data[rth_pkg::COORD_W-1:0];
                    rth_pkg::CFG_ORG_Y: org_y   = i_cfg_data[rth_pkg::COORD_W-1:0];
                    rth_pkg::CFG_ORG_Z: org_z   = i_cfg_data[rth_pkg::COORD_W-1:0];
                    rth_pkg::CFG_DIR_X: dir_x   = i_cfg_data[rth_pkg::COORD_W-1:0];
                    rth_pkg::CFG_DIR_Y: dir_y   = i_cfg_data[rth_pkg::COORD_W-1:0];
                    rth_pkg::CFG_DIR_Z: dir_z   = i_cfg_data[rth_pkg::COORD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_hits.size();
    end

endmodule

// ===== sim/ray_triangle_hit_test_tb.sv =====
// Testbench top for ray_triangle_hit_test: drives rays and triangle items (random
// gaps in some batches) and gives the verdict. Depends on the DUT, rth_pkg, rth_hit_checker.
module ray_triangle_hit_test_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CMIN = -32768;
    localparam int CMAX = 32767;
    localparam logic [rth_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // unmapped index
    localparam logic [rth_pkg::TOL_W-1:0]     TOL_MAX   = '1;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           start    = 1'b0;
    rth_pkg::t_item                 item     = '0;
    logic                           cfg_we   = 1'b0;
    logic [rth_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [rth_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           busy;
    logic                           valid;
    rth_pkg::t_result               result;
    int                             fail_count;
    int                             pending;
    int                             idle_cycles = 0;

    // Current ray, kept for aiming triangles at it
    int ray_o[3];
    int ray_d[3];

    always #5 clk = ~clk;

    ray_triangle_hit_test dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_item     (item),
        .o_busy     (busy),
        .o_valid    (valid),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rth_hit_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_valid      (valid),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: too long without an accepted item or a result ends the run
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL ray_triangle_hit_test");
                $finish;
            end
        end
    end

    function automatic logic [rth_pkg::CFG_DATA_W-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[rth_pkg::CFG_DATA_W-1:0];
    endfunction

    // Coordinate register word, sometimes with junk above the field
    function automatic logic [rth_pkg::CFG_DATA_W-1:0] coord_word(int v);
        logic [rth_pkg::CFG_DATA_W-1:0] w;
        w = rand_word();
        if ($urandom_range(0, 1))
            w = {{(rth_pkg::CFG_DATA_W-rth_pkg::COORD_W){v[rth_pkg::COORD_W-1]}},
                 v[rth_pkg::COORD_W-1:0]};
        else
            w[rth_pkg::COORD_W-1:0] = v[rth_pkg::COORD_W-1:0];
        return w;
    endfunction

    function automatic int clamp16(int v);
        if (v < CMIN) return CMIN;
        if (v > CMAX) return CMAX;
        return v;
    endfunction

    function automatic int spread(int n);
        return int'($urandom_range(0, 2 * n)) - n;
    endfunction

    function automatic rth_pkg::t_item mk_tri(int a_x, int a_y, int a_z,
                                              int b_x, int b_y, int b_z,
                                              int c_x, int c_y, int c_z, bit cul);
        rth_pkg::t_item t;
        t.ax = a_x[rth_pkg::COORD_W-1:0];
        t.ay = a_y[rth_pkg::COORD_W-1:0];
        t.az = a_z[rth_pkg::COORD_W-1:0];
        t.bx = b_x[rth_pkg::COORD_W-1:0];
        t.by_coord = b_y[rth_pkg::COORD_W-1:0];
        t.bz = b_z[rth_pkg::COORD_W-1:0];
        t.cx = c_x[rth_pkg::COORD_W-1:0];
        t.cy = c_y[rth_pkg::COORD_W-1:0];
        t.cz = c_z[rth_pkg::COORD_W-1:0];
        t.face_culled = cul;
        return t;
    endfunction

    function automatic rth_pkg::t_item rand_tri();
        logic [159:0]   r;
        rth_pkg::t_item t;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        t = r[$bits(rth_pkg::t_item)-1:0];
        return t;
    endfunction

    // Triangle scattered around a point on the ray line (sometimes behind the origin)
    function automatic rth_pkg::t_item near_ray_tri();
        int tp, r;
        int p[3];
        int v[9];
        tp = int'($urandom_range(0, 48)) - 8;
        case ($urandom_range(0, 2))
            0:       r = 64;
            1:       r = 2000;
            default: r = 12000;
        endcase
        for (int i = 0; i < 3; i++)
            p[i] = ray_o[i] + tp * ray_d[i];
        for (int i = 0; i < 9; i++)
            v[i] = clamp16(p[i % 3] + spread(r));
        return mk_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                      $urandom_range(0, 99) < 8);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_tri(rth_pkg::t_item t);
        start <= 1'b1;
        item  <= t;
        do @(posedge clk); while (busy);
    endtask

    // Wait until every expected result is back and the pipeline has drained
    task automatic settle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (rth_pkg::LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [rth_pkg::CFG_IDX_W-1:0] idx,
                             logic [rth_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_ray(logic [rth_pkg::TOL_W-1:0] tol, int ox, int oy, int oz,
                            int dx, int dy, int dz);
        settle();
        write_reg(rth_pkg::CFG_TOL, (rth_pkg::CFG_DATA_W)'(tol));
        write_reg(rth_pkg::CFG_ORG_X, coord_word(ox));
        write_reg(rth_pkg::CFG_ORG_Y, coord_word(oy));
        write_reg(rth_pkg::CFG_ORG_Z, coord_word(oz));
        write_reg(rth_pkg::CFG_DIR_X, coord_word(dx));
        write_reg(rth_pkg::CFG_DIR_Y, coord_word(dy));
        write_reg(rth_pkg::CFG_DIR_Z, coord_word(dz));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SPARE, rand_word());
        cfg_we <= 1'b0;
        ray_o = '{ox, oy, oz};
        ray_d = '{dx, dy, dz};
    endtask

    task automatic run_batch(int n, int near_pct, bit no_gaps);
        int             gap;
        rth_pkg::t_item t;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < near_pct) t = near_ray_tri();
            else t = rand_tri();
            send_tri(t);
            gap = no_gaps ? 0 : gap_len();
            if (gap > 0 || k == n - 1) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial begin
        int sel;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset: zero direction, everything not culled is parallel
        send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(rand_tri());
        send_tri(mk_tri(-100, -100, 0, 100, -100, 0, 0, 100, 0, 1));
        start <= 1'b0;

        // ray along +z from below the z=0 plane
        load_ray(0, 0, 0, -100, 0, 0, 1);
        send_tri(mk_tri(-100, -100, 0, 100, -100, 0, 0, 100, 0, 0));
        send_tri(mk_tri(-100, -100, 0, 0, 100, 0, 100, -100, 0, 0));    // other winding
        send_tri(mk_tri(-100, -100, 0, 100, -100, 0, 0, 100, 0, 1));    // culled
        send_tri(mk_tri(-100, -100, -200, 100, -100, -200, 0, 100, -200, 0)); // behind
        send_tri(mk_tri(200, -100, 0, 400, -100, 0, 300, 100, 0, 0));
        send_tri(mk_tri(-400, -100, 0, -200, -100, 0, -300, 100, 0, 0));
        send_tri(mk_tri(-100, 200, 0, 100, 200, 0, 0, 400, 0, 0));
        send_tri(mk_tri(-100, -400, 0, 100, -400, 0, 0, -200, 0, 0));
        send_tri(mk_tri(0, 0, 0, 100, 0, 0, 0, 100, 0, 0));            // ray through a vertex
        send_tri(mk_tri(-100, -100, -100, 100, -100, -100, 0, 100, -100, 0)); // origin on plane
        send_tri(mk_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 0));                // degenerate
        send_tri(mk_tri(0, 0, 0, 10, 10, 0, 20, 20, 0, 0));            // collinear
        send_tri(mk_tri(0, 0, 0, 0, 0, 100, 100, 0, 0, 0));            // edge-on
        send_tri(mk_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, 0, CMAX, CMIN, 0));
        start <= 1'b0;

        // tolerance right at |D.N| of the first triangle, then just under, then max
        load_ray(40000, 0, 0, -100, 0, 0, 1);
        send_tri(mk_tri(-100, -100, 0, 100, -100, 0, 0, 100, 0, 0));
        start <= 1'b0;
        load_ray(39999, 0, 0, -100, 0, 0, 1);
        send_tri(mk_tri(-100, -100, 0, 100, -100, 0, 0, 100, 0, 0));
        start <= 1'b0;
        load_ray(TOL_MAX, 0, 0, -100, 0, 0, 1);
        send_tri(mk_tri(-100, -100, 0, 100, -100, 0, 0, 100, 0, 0));
        start <= 1'b0;

        // ray with extreme origin and direction
        load_ray(0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_tri(mk_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, 0, CMAX, CMIN, 0));
        send_tri(mk_tri(CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 0));
        send_tri(rand_tri());
        start <= 1'b0;

        // random phases, one ray setting each
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_ray(0, spread(8000), spread(8000), spread(8000),
                            spread(512), spread(512), spread(512));
                1: load_ray(TOL_MAX, spread(8000), spread(8000), spread(8000),
                            spread(512), spread(512), spread(512));
                2: load_ray({{(rth_pkg::TOL_W-32){1'b0}}, $urandom},
                            spread(8000), spread(8000), spread(8000),
                            spread(512), spread(512), spread(512));
                3: begin
                    sel = $urandom;
                    load_ray(0, sel[0] ? CMAX : CMIN, sel[1] ? CMAX : CMIN,
                             sel[2] ? CMAX : CMIN, sel[3] ? CMAX : CMIN,
                             sel[4] ? CMAX : CMIN, sel[5] ? CMAX : CMIN);
                end
                4: load_ray(rand_word(), spread(8000), spread(8000), spread(8000), 0, 0, 0);
                5: load_ray(0, spread(32767), spread(32767), spread(32767),
                            spread(32767), spread(32767), spread(32767));
                6: load_ray({{(rth_pkg::TOL_W-16){1'b0}}, 16'($urandom)},
                            spread(4000), spread(4000), spread(4000),
                            spread(16), spread(16), spread(16));
                default: load_ray(rand_word(), spread(8000), spread(8000), spread(8000),
                                  spread(512), spread(512), spread(512));
            endcase
            run_batch(205, (ph == 1 || ph == 4) ? 30 : 75, (ph % 3) == 0);
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("PASS ray_triangle_hit_test");
        else
            $display("FAIL ray_triangle_hit_test");
        $finish;
    end

endmodule

// ===== files.f =====
design/rth_pkg.sv
design/rth_cross.sv
design/rth_dot.sv
design/ray_triangle_hit_test.sv
design/rth_check.sv
sim/rth_hit_checker.sv
sim/ray_triangle_hit_test_tb.sv
